FILE: hdl/rational_arithmetic_unit_core_macros.svh
// Assertion macros for the rational arithmetic unit core.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define RAU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rau: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge
`define RAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rau: next-cycle check failed");

`endif

FILE: hdl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int DEN_BITS  = WORD_BITS - 1;
   localparam int WIDE_BITS = 2 * WORD_BITS;
   localparam int CNT_BITS  = $clog2(WIDE_BITS);

   // 2^(WORD_BITS-1) in the wide datapath
   localparam logic [WIDE_BITS-1:0] NUM_LIM = WIDE_BITS'(1) << (WORD_BITS - 1);

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_MUL  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Datapath commands
   typedef enum logic [4:0] {
      CMD_LOAD,
      CMD_MUL_P,
      CMD_MUL_D,
      CMD_MUL_M1,
      CMD_MUL_L,
      CMD_MUL_M2,
      CMD_DIV_T0,
      CMD_DIV_T1,
      CMD_DIV_AD,
      CMD_DIV_BD,
      CMD_GCD_T,
      CMD_GCD_DEN,
      CMD_SUM,
      CMD_EMIT_Z,
      CMD_EMIT_A,
      CMD_EMIT_B,
      CMD_EMIT_T
   } dp_cmd_type;

   typedef struct packed {
      logic       start;
      dp_cmd_type code;
   } rau_cmd_type;

   typedef struct packed {
      op_type op;
      logic   ad_zero;
      logic   bd_zero;
      logic   sum_zero;
      logic   done;
      logic   out_free;
   } rau_status_type;

endpackage

FILE: hdl/rau_datapath.sv
// Datapath: operand registers, shared multiply/divide/gcd engine and result register.
`timescale 1ns / 1ps
module rau_datapath
   import rau_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  rau_cmd_type                 cmd,
   output rau_status_type              status,
   input  logic [1:0]                  req_operation,
   input  logic signed [WORD_BITS-1:0] req_a_num,
   input  logic [DEN_BITS-1:0]         req_a_den,
   input  logic signed [WORD_BITS-1:0] req_b_num,
   input  logic [DEN_BITS-1:0]         req_b_den,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_res_num,
   output logic [DEN_BITS-1:0]         rsp_res_den,
   output logic                        rsp_overflow
);

   typedef enum logic [1:0] {
      ENG_NONE,
      ENG_MUL,
      ENG_DIV,
      ENG_GCD
   } eng_type;

   // operand registers
   op_type                 op_ff;
   logic [WORD_BITS-1:0]   amag_ff, bmag_ff;
   logic                   aneg_ff, bneg_ff, sneg_ff;
   logic [DEN_BITS-1:0]    ad_ff, bd_ff;
   logic [WIDE_BITS-1:0]   t0_ff, t1_ff, t2_ff, t3_ff;

   // engine registers
   dp_cmd_type             eng_cmd_ff;
   logic [WIDE_BITS-1:0]   x_ff, y_ff, acc_ff;
   logic [WORD_BITS-1:0]   mq_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [CNT_BITS-1:0]    k_ff;
   logic                   busy_ff, done_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [WORD_BITS-1:0]   res_num_ff;
   logic [DEN_BITS-1:0]    res_den_ff;
   logic                   res_ovf_ff;

   eng_type                start_kind, run_kind;
   logic [WIDE_BITS-1:0]   mul_sum;
   logic [WIDE_BITS:0]     div_shift, div_diff;
   logic                   div_ge;
   logic                   eng_fin;
   logic [WIDE_BITS-1:0]   eng_res;
   logic [WIDE_BITS-1:0]   sum_mag;
   logic                   sum_neg;
   logic                   emit_go, e_neg, e_ovf;
   logic [WIDE_BITS-1:0]   e_mag, e_den, e_num;
   logic                   start_now;

   // engine class of a command
   function automatic eng_type kind_of(input dp_cmd_type c);
      eng_type k;
      case (c)
         CMD_MUL_P, CMD_MUL_D, CMD_MUL_M1, CMD_MUL_L, CMD_MUL_M2: k = ENG_MUL;
         CMD_DIV_T0, CMD_DIV_T1, CMD_DIV_AD, CMD_DIV_BD:          k = ENG_DIV;
         CMD_GCD_T, CMD_GCD_DEN:                                  k = ENG_GCD;
         default:                                                 k = ENG_NONE;
      endcase
      return k;
   endfunction

   assign start_kind = kind_of(cmd.code);
   assign run_kind   = kind_of(eng_cmd_ff);
   assign start_now  = cmd.start && (start_kind != ENG_NONE);

   // one step of each engine mode
   assign mul_sum   = acc_ff + (mq_ff[0] ? x_ff : '0);
   assign div_shift = {acc_ff, x_ff[WIDE_BITS-1]};
   assign div_ge    = div_shift >= {1'b0, y_ff};
   assign div_diff  = div_shift - {1'b0, y_ff};

   always_comb begin
      eng_fin = 1'b0;
      eng_res = '0;
      case (run_kind)
         ENG_MUL: begin
            eng_fin = (cnt_ff == CNT_BITS'(WORD_BITS - 1));
            eng_res = mul_sum;
         end
         ENG_DIV: begin
            eng_fin = (cnt_ff == CNT_BITS'(WIDE_BITS - 1));
            eng_res = {x_ff[WIDE_BITS-2:0], div_ge};
         end
         ENG_GCD: begin
            eng_fin = (x_ff == '0) || (y_ff == '0);
            eng_res = ((x_ff == '0) ? y_ff : x_ff) << k_ff;
         end
         default: begin
            eng_fin = 1'b0;
            eng_res = '0;
         end
      endcase
   end

   // signed sum of the scaled numerators (m1 in t3, m2 in t0)
   always_comb begin
      if (aneg_ff == bneg_ff) begin
         sum_mag = t3_ff + t0_ff;
         sum_neg = aneg_ff;
      end else if (t3_ff >= t0_ff) begin
         sum_mag = t3_ff - t0_ff;
         sum_neg = aneg_ff;
      end else begin
         sum_mag = t0_ff - t3_ff;
         sum_neg = bneg_ff;
      end
   end

   // result selection and range check
   always_comb begin
      e_neg = 1'b0;
      e_mag = '0;
      e_den = '0;
      case (cmd.code)
         CMD_EMIT_A: begin
            e_neg = aneg_ff && (amag_ff != '0);
            e_mag = WIDE_BITS'(amag_ff);
            e_den = WIDE_BITS'(ad_ff);
         end
         CMD_EMIT_B: begin
            e_neg = bneg_ff && (bmag_ff != '0);
            e_mag = WIDE_BITS'(bmag_ff);
            e_den = WIDE_BITS'(bd_ff);
         end
         CMD_EMIT_T: begin
            e_neg = sneg_ff;
            e_mag = t0_ff;
            e_den = t1_ff;
         end
         default: begin
            e_neg = 1'b0;
            e_mag = '0;
            e_den = '0;
         end
      endcase
      e_ovf = (e_den > NUM_LIM - 1'b1) ||
              (e_neg ? (e_mag > NUM_LIM) : (e_mag > NUM_LIM - 1'b1));
      e_num = e_neg ? ('0 - e_mag) : e_mag;
   end

   assign emit_go = cmd.start && ((cmd.code == CMD_EMIT_Z) || (cmd.code == CMD_EMIT_A) ||
                                  (cmd.code == CMD_EMIT_B) || (cmd.code == CMD_EMIT_T));

   // engine and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start_now) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && eng_fin) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // operand load and command set-up
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         case (cmd.code)
            CMD_LOAD: begin
               op_ff   <= op_type'(req_operation);
               aneg_ff <= req_a_num[WORD_BITS-1];
               amag_ff <= req_a_num[WORD_BITS-1] ? ('0 - req_a_num) : req_a_num;
               bneg_ff <= req_b_num[WORD_BITS-1] ^ (op_type'(req_operation) == OP_SUB);
               bmag_ff <= req_b_num[WORD_BITS-1] ? ('0 - req_b_num) : req_b_num;
               ad_ff   <= req_a_den;
               bd_ff   <= req_b_den;
            end
            CMD_SUM: begin
               t0_ff   <= sum_mag;
               sneg_ff <= sum_neg;
            end
            default: begin
            end
         endcase
      end
      if (start_now) begin
         eng_cmd_ff <= cmd.code;
         acc_ff     <= '0;
         cnt_ff     <= '0;
         k_ff       <= '0;
         // each mode loads only the operands it steps on
         case (cmd.code)
            CMD_MUL_P: begin
               x_ff    <= WIDE_BITS'(amag_ff);
               mq_ff   <= bmag_ff;
               sneg_ff <= aneg_ff ^ bneg_ff;
            end
            CMD_MUL_D: begin
               x_ff  <= WIDE_BITS'(ad_ff);
               mq_ff <= WORD_BITS'(bd_ff);
            end
            CMD_MUL_M1: begin
               x_ff  <= t1_ff;
               mq_ff <= amag_ff;
            end
            CMD_MUL_L: begin
               x_ff  <= t0_ff;
               mq_ff <= WORD_BITS'(bd_ff);
            end
            CMD_MUL_M2: begin
               x_ff  <= t0_ff;
               mq_ff <= bmag_ff;
            end
            CMD_DIV_T0: begin
               x_ff <= t0_ff;
               y_ff <= t2_ff;
            end
            CMD_DIV_T1: begin
               x_ff <= t1_ff;
               y_ff <= t2_ff;
            end
            CMD_DIV_AD: begin
               x_ff <= WIDE_BITS'(ad_ff);
               y_ff <= t2_ff;
            end
            CMD_DIV_BD: begin
               x_ff <= WIDE_BITS'(bd_ff);
               y_ff <= t2_ff;
            end
            CMD_GCD_T: begin
               x_ff <= t0_ff;
               y_ff <= t1_ff;
            end
            CMD_GCD_DEN: begin
               x_ff <= WIDE_BITS'(ad_ff);
               y_ff <= WIDE_BITS'(bd_ff);
            end
            default: begin
            end
         endcase
      end else if (busy_ff) begin
         // one engine step
         cnt_ff <= cnt_ff + 1'b1;
         case (run_kind)
            ENG_MUL: begin
               acc_ff <= mul_sum;
               x_ff   <= x_ff << 1;
               mq_ff  <= mq_ff >> 1;
            end
            ENG_DIV: begin
               acc_ff <= div_ge ? div_diff[WIDE_BITS-1:0] : div_shift[WIDE_BITS-1:0];
               x_ff   <= {x_ff[WIDE_BITS-2:0], div_ge};
            end
            ENG_GCD: begin
               if (eng_fin) begin
               end else if (!x_ff[0] && !y_ff[0]) begin
                  x_ff <= x_ff >> 1;
                  y_ff <= y_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else if (x_ff >= y_ff) begin
                  x_ff <= x_ff - y_ff;
               end else begin
                  y_ff <= y_ff - x_ff;
               end
            end
            default: begin
            end
         endcase
         // write back the finished value
         if (eng_fin) begin
            case (eng_cmd_ff)
               CMD_MUL_P, CMD_DIV_T0, CMD_DIV_AD, CMD_MUL_M2: t0_ff <= eng_res;
               CMD_MUL_D, CMD_DIV_T1, CMD_DIV_BD, CMD_MUL_L:  t1_ff <= eng_res;
               CMD_GCD_T, CMD_GCD_DEN:                        t2_ff <= eng_res;
               CMD_MUL_M1:                                    t3_ff <= eng_res;
               default: begin
               end
            endcase
         end
      end
      if (emit_go) begin
         res_num_ff <= e_num[WORD_BITS-1:0];
         res_den_ff <= e_den[DEN_BITS-1:0];
         res_ovf_ff <= e_ovf;
      end
   end

   assign status.op       = op_ff;
   assign status.ad_zero  = (ad_ff == '0);
   assign status.bd_zero  = (bd_ff == '0);
   assign status.sum_zero = (t0_ff == '0);
   assign status.done     = done_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_overflow = res_ovf_ff;

endmodule

FILE: hdl/rau_controller.sv
// Controller: sequences the datapath commands for one request.
`timescale 1ns / 1ps
module rau_controller
   import rau_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  rau_status_type status,
   output rau_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_MUL_P,
      S_MUL_D,
      S_GCD_DEN,
      S_DIV_AD,
      S_DIV_BD,
      S_MUL_M1,
      S_MUL_L,
      S_MUL_M2,
      S_SUM,
      S_CHECK,
      S_GCD_T,
      S_DIV_T0,
      S_DIV_T1,
      S_EMIT_Z,
      S_EMIT_A,
      S_EMIT_B,
      S_EMIT_T
   } state_type;

   state_type state_ff, seq_next;
   logic      issued_ff;
   logic      multi;

   // command per state, and the follow-on state of each engine step
   always_comb begin
      cmd.start = 1'b0;
      cmd.code  = CMD_LOAD;
      multi     = 1'b1;
      seq_next  = S_IDLE;
      case (state_ff)
         S_IDLE: begin
            multi     = 1'b0;
            cmd.start = req_valid;
         end
         S_MUL_P:   begin cmd.code = CMD_MUL_P;   seq_next = S_MUL_D;   end
         S_MUL_D:   begin cmd.code = CMD_MUL_D;   seq_next = S_GCD_T;   end
         S_GCD_DEN: begin cmd.code = CMD_GCD_DEN; seq_next = S_DIV_AD;  end
         S_DIV_AD:  begin cmd.code = CMD_DIV_AD;  seq_next = S_DIV_BD;  end
         S_DIV_BD:  begin cmd.code = CMD_DIV_BD;  seq_next = S_MUL_M1;  end
         S_MUL_M1:  begin cmd.code = CMD_MUL_M1;  seq_next = S_MUL_L;   end
         S_MUL_L:   begin cmd.code = CMD_MUL_L;   seq_next = S_MUL_M2;  end
         S_MUL_M2:  begin cmd.code = CMD_MUL_M2;  seq_next = S_SUM;     end
         S_GCD_T:   begin cmd.code = CMD_GCD_T;   seq_next = S_DIV_T0;  end
         S_DIV_T0:  begin cmd.code = CMD_DIV_T0;  seq_next = S_DIV_T1;  end
         S_DIV_T1:  begin cmd.code = CMD_DIV_T1;  seq_next = S_EMIT_T;  end
         S_SUM: begin
            multi     = 1'b0;
            cmd.start = 1'b1;
            cmd.code  = CMD_SUM;
         end
         S_EMIT_Z: begin multi = 1'b0; cmd.start = status.out_free; cmd.code = CMD_EMIT_Z; end
         S_EMIT_A: begin multi = 1'b0; cmd.start = status.out_free; cmd.code = CMD_EMIT_A; end
         S_EMIT_B: begin multi = 1'b0; cmd.start = status.out_free; cmd.code = CMD_EMIT_B; end
         S_EMIT_T: begin multi = 1'b0; cmd.start = status.out_free; cmd.code = CMD_EMIT_T; end
         default: begin
            multi = 1'b0;
         end
      endcase
      if (multi) begin
         cmd.start = !issued_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               case (status.op)
                  OP_MUL: begin
                     if (status.ad_zero || status.bd_zero) begin
                        state_ff <= S_EMIT_Z;
                     end else begin
                        state_ff <= S_MUL_P;
                     end
                  end
                  OP_ADD, OP_SUB: begin
                     if (status.ad_zero && status.bd_zero) begin
                        state_ff <= S_EMIT_Z;
                     end else if (status.ad_zero) begin
                        state_ff <= S_EMIT_B;
                     end else if (status.bd_zero) begin
                        state_ff <= S_EMIT_A;
                     end else begin
                        state_ff <= S_GCD_DEN;
                     end
                  end
                  default: begin
                     state_ff <= S_EMIT_Z;
                  end
               endcase
            end
            S_SUM: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= status.sum_zero ? S_EMIT_Z : S_GCD_T;
            end
            S_EMIT_Z, S_EMIT_A, S_EMIT_B, S_EMIT_T: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               // engine steps: issue once, then wait for completion
               if (!issued_ff) begin
                  issued_ff <= 1'b1;
               end else if (status.done) begin
                  issued_ff <= 1'b0;
                  state_ff  <= seq_next;
               end
            end
         endcase
      end
   end

endmodule

FILE: hdl/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: controller plus datapath.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   operation, a_num, a_den, b_num, b_den
//   rsp       out        rsp_valid/rsp_stall   res_num, res_den, overflow
//
// One request at a time. Multiply, divide and binary gcd steps all run in turn on one
// shared iterative engine; empty-operand cases skip the engine and go to an emit state.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
// The result register frees the engine: a new request is taken while a result waits,
// and only a second result, ready before the first is taken, holds the sequencer.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_core_macros.svh"
module rational_arithmetic_unit_core
   import rau_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic signed [WORD_BITS-1:0] req_a_num,
   input  logic [DEN_BITS-1:0]         req_a_den,
   input  logic signed [WORD_BITS-1:0] req_b_num,
   input  logic [DEN_BITS-1:0]         req_b_den,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_res_num,
   output logic [DEN_BITS-1:0]         rsp_res_den,
   output logic                        rsp_overflow
);

   rau_cmd_type    cmd;
   rau_status_type status;

   // sequencer
   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and result register
   rau_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_operation),
      .req_a_num     (req_a_num),
      .req_a_den     (req_a_den),
      .req_b_num     (req_b_num),
      .req_b_den     (req_b_den),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_res_num   (rsp_res_num),
      .rsp_res_den   (rsp_res_den),
      .rsp_overflow  (rsp_overflow)
   );

   // a taken request keeps the block busy
   `RAU_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)
   // a new result only comes out of a running request
   `RAU_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(req_stall))
   // an in-range result with a zero denominator is exactly 0/0
   `RAU_ASSERT_NOW(a_empty_result, rsp_valid && (rsp_res_den == '0) && !rsp_overflow, rsp_res_num == '0)

endmodule

FILE: verif/rational_arithmetic_unit_core_test.sv
// Self-checking testbench for the rational arithmetic unit core.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core_test;
   import rau_pkg::*;

   typedef struct {
      op_type           op;
      logic [31:0]      a_num;
      logic [30:0]      a_den;
      logic [31:0]      b_num;
      logic [30:0]      b_den;
   } fraction_request_type;

   typedef struct {
      logic [31:0] num;
      logic [30:0] den;
      logic        ovf;
   } fraction_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [31:0] req_a_num;
   logic [30:0] req_a_den;
   logic [31:0] req_b_num;
   logic [30:0] req_b_den;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic        rsp_overflow;

   fraction_request_type pending_requests[$];
   fraction_result_type  expected_results[$];
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_off_cycles;
   bit   req_taken;
   bit   any_failure;

   rational_arithmetic_unit_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [127:0] gcd_wide(logic [127:0] x, logic [127:0] y);
      logic [127:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Signs the magnitude, truncates to port widths and flags out-of-range values
   function automatic fraction_result_type pack_fraction(bit neg, logic [127:0] mag,
                                                         logic [127:0] den);
      fraction_result_type r;
      logic [127:0] lim;
      logic [127:0] signed_num;
      lim = 128'd1 << 31;
      r.ovf = (den > lim - 1) || (neg ? (mag > lim) : (mag > lim - 1));
      signed_num = neg ? (128'd0 - mag) : mag;
      r.num = signed_num[31:0];
      r.den = den[30:0];
      return r;
   endfunction

   function automatic fraction_result_type predict_fraction(fraction_request_type q);
      bit           a_neg, b_neg, s_neg;
      logic [127:0] a_mag, b_mag, ad, bd, g, l, m1, m2, sm, pm, pd;
      a_neg = q.a_num[31];
      b_neg = q.b_num[31];
      a_mag = a_neg ? 128'(-{1'b1, q.a_num}) & 128'h1_FFFF_FFFF : 128'(q.a_num);
      b_mag = b_neg ? 128'(-{1'b1, q.b_num}) & 128'h1_FFFF_FFFF : 128'(q.b_num);
      ad = 128'(q.a_den);
      bd = 128'(q.b_den);
      if (q.op == OP_NONE) return pack_fraction(0, 0, 0);
      if (q.op == OP_MUL) begin
         if (ad == 0 || bd == 0) return pack_fraction(0, 0, 0);
         pm = a_mag * b_mag;
         pd = ad * bd;
         g = gcd_wide(pm, pd);
         if (pm == 0) return pack_fraction(0, 0, pd / g);
         return pack_fraction(a_neg != b_neg, pm / g, pd / g);
      end
      if (q.op == OP_SUB) b_neg = !b_neg;
      if (ad == 0 && bd == 0) return pack_fraction(0, 0, 0);
      if (ad == 0) return pack_fraction(b_neg && b_mag != 0, b_mag, bd);
      if (bd == 0) return pack_fraction(a_neg && a_mag != 0, a_mag, ad);
      g = gcd_wide(ad, bd);
      l = (ad / g) * bd;
      m1 = a_mag * (bd / g);
      m2 = b_mag * (ad / g);
      if (a_neg == b_neg) begin
         sm = m1 + m2;
         s_neg = a_neg;
      end else if (m1 >= m2) begin
         sm = m1 - m2;
         s_neg = a_neg;
      end else begin
         sm = m2 - m1;
         s_neg = b_neg;
      end
      if (sm == 0) return pack_fraction(0, 0, 0);
      g = gcd_wide(sm, l);
      return pack_fraction(s_neg, sm / g, l / g);
   endfunction

   // Random operand: small values half the time, otherwise extremes or full range
   function automatic logic [31:0] random_num();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'(-$urandom_range(0, 100));
         default: return 32'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic logic [30:0] random_den();
      case ($urandom_range(0, 6))
         0: return 31'd0;
         1: return 31'($urandom());
         2: return 31'h7FFF_FFFF;
         3: return 31'($urandom_range(1, 65535));
         default: return 31'($urandom_range(1, 60));
      endcase
   endfunction

   task automatic queue_request(op_type op, logic [31:0] an, logic [30:0] ad,
                                logic [31:0] bn, logic [30:0] bd);
      fraction_request_type q;
      q.op = op;
      q.a_num = an;
      q.a_den = ad;
      q.b_num = bn;
      q.b_den = bd;
      pending_requests.push_back(q);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: a new request only once the offered one has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_operation <= pending_requests[0].op;
            req_a_num     <= pending_requests[0].a_num;
            req_a_den     <= pending_requests[0].a_den;
            req_b_num     <= pending_requests[0].b_num;
            req_b_den     <= pending_requests[0].b_den;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict and retire the request on acceptance
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(predict_fraction(pending_requests[0]));
         void'(pending_requests.pop_front());
         req_taken = 1'b1;
      end
   end

   // Result stall, with a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      fraction_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result num=%h den=%h", rsp_res_num, rsp_res_den);
            any_failure = 1'b1;
         end else begin
            e = expected_results.pop_front();
            if (rsp_res_num !== e.num) begin
               $error("res_num: expected %h, got %h", e.num, rsp_res_num);
               any_failure = 1'b1;
            end
            if (rsp_res_den !== e.den) begin
               $error("res_den: expected %h, got %h", e.den, rsp_res_den);
               any_failure = 1'b1;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow: expected %b, got %b", e.ovf, rsp_overflow);
               any_failure = 1'b1;
            end
         end
      end
   end

   initial begin
      #400_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      op_type op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ADD;
      req_a_num = '0;
      req_a_den = '0;
      req_b_num = '0;
      req_b_den = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 0;
      any_failure = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empties, zero sums, extremes, every operation
      queue_request(OP_ADD, 32'd5, 31'd0, 32'd7, 31'd0);
      queue_request(OP_SUB, 32'd5, 31'd0, 32'd7, 31'd0);
      queue_request(OP_ADD, 32'd5, 31'd0, 32'd7, 31'd3);
      queue_request(OP_SUB, 32'd5, 31'd0, 32'd7, 31'd3);
      queue_request(OP_SUB, 32'd5, 31'd0, 32'h8000_0000, 31'd3);
      queue_request(OP_ADD, -32'd9, 31'd4, 32'd7, 31'd0);
      queue_request(OP_ADD, 32'd1, 31'd2, -32'd1, 31'd2);
      queue_request(OP_SUB, 32'd3, 31'd6, 32'd1, 31'd2);
      queue_request(OP_ADD, 32'd1, 31'd6, 32'd1, 31'd3);
      queue_request(OP_MUL, 32'd0, 31'd5, 32'd7, 31'd3);
      queue_request(OP_MUL, 32'd4, 31'd0, 32'd7, 31'd3);
      queue_request(OP_MUL, -32'd4, 31'd6, 32'd3, 31'd8);
      queue_request(OP_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1);
      queue_request(OP_MUL, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
      queue_request(OP_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
      queue_request(OP_SUB, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFE);
      queue_request(OP_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFD);
      queue_request(OP_NONE, 32'd1, 31'd2, 32'd3, 31'd4);
      queue_request(OP_NONE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      wait_drained();

      // Random phases with different idling mixes
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 32 : 0;
         for (int i = 0; i < 600; i++) begin
            op = ($urandom_range(0, 19) == 0) ? OP_NONE : op_type'($urandom_range(0, 2));
            queue_request(op, random_num(), random_den(), random_num(), random_den());
            if (i == 300 && phase == 2) begin
               // long receiver hold-off while requests keep coming
               @(negedge clock);
               hold_off_cycles <= 3000;
            end
            if (i == 450) wait_drained();
            if (pending_requests.size() > 8)
               while (pending_requests.size() > 2) @(posedge clock);
         end
         wait_drained();
      end
      repeat (2000) @(posedge clock);
      if (!any_failure && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (expected_results.size() != 0)
            $error("%0d results never arrived", expected_results.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_datapath.sv
hdl/rau_controller.sv
hdl/rational_arithmetic_unit_core.sv
verif/rational_arithmetic_unit_core_test.sv
